// File: sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  // default line buffer depth
  localparam int LINE_LEN_DEF = 64;

  // field widths fixed by the interface
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // control characters
  localparam logic [BYTE_W-1:0] CH_BREAK = 8'h03;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_KILL  = 8'h15;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  // command field codes
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // queue between classifier and sequencer
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // operation class decided by the front end
  typedef enum logic [2:0] {
    OP_READ,
    OP_BREAK,
    OP_BS,
    OP_DEL,
    OP_KILL,
    OP_CR,
    OP_LF,
    OP_CHAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } qent_t;

endpackage

// File: sv/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Classifies each incoming item into an operation and pushes it to the queue.
// ----------------------------------------------------------------------------
module tle_front (
  input  logic                  in_valid,
  input  logic                  in_cmd,
  input  logic [7:0]            in_rx_byte,
  input  logic [5:0]            in_read_index,
  output logic                  push_valid,
  output tle_pkg::qent_t        push_ent
);
  import tle_pkg::*;

  op_t op;

  always_comb begin
    if (in_cmd == CMD_READ) begin
      op = OP_READ;
    end else begin
      case (in_rx_byte)
        CH_BREAK: op = OP_BREAK;
        CH_BS:    op = OP_BS;
        CH_DEL:   op = OP_DEL;
        CH_KILL:  op = OP_KILL;
        CH_CR:    op = OP_CR;
        CH_LF:    op = OP_LF;
        default:  op = OP_CHAR;
      endcase
    end
  end

  assign push_valid   = in_valid;
  assign push_ent.op  = op;
  assign push_ent.ch  = in_rx_byte;
  assign push_ent.idx = in_read_index;

endmodule

// File: sv/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue
// Short FIFO that decouples the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module tle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  tle_pkg::qent_t push_ent,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tle_pkg::qent_t pop_ent
);
  import tle_pkg::*;

  qent_t           ent_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_ready && pop_valid;
  assign pop_ent   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// File: sv/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Executes queued operations: line edit state, line memory, result sequencing.
// ----------------------------------------------------------------------------
module tle_back #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  tle_pkg::qent_t pop_ent,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_echo_valid,
  output logic [7:0]     out_echo_byte,
  output logic           out_break_event,
  output logic           out_line_done,
  output logic [6:0]     out_line_length,
  output logic           out_overflow,
  output logic [7:0]     out_read_data,
  output logic           out_last
);
  import tle_pkg::*;

  localparam int PW        = $clog2(LINE_LEN);
  // address is {bank, position}, so each bank spans the full position range
  localparam int MEM_DEPTH = 2 ** (PW + 1);

  typedef enum logic {S_IDLE, S_SEQ} state_t;

  // resolved action for the sequencer
  typedef enum logic [3:0] {
    A_READ, A_BREAK, A_NONE, A_OVF, A_BS, A_DEL, A_KILL, A_CHAR, A_CR, A_LF
  } act_t;

  state_t            state_r, state_nxt;
  act_t              act_r, act_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] ch_r, ch_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [LEN_W-1:0]  prev_len_r, prev_len_nxt;
  logic [PW-1:0]     cursor_r, cursor_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              bank_r, bank_nxt;

  logic              ov_r, ov_nxt;
  logic              o_ev_r, o_ev_nxt;
  logic [BYTE_W-1:0] o_eb_r, o_eb_nxt;
  logic              o_brk_r, o_brk_nxt;
  logic              o_done_r, o_done_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  logic              o_ovf_r, o_ovf_nxt;
  logic [BYTE_W-1:0] o_rd_r, o_rd_nxt;
  logic              o_last_r, o_last_nxt;

  // two banks: one being edited, the other holds the completed line
  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic              mem_we, mem_re;
  logic [PW:0]       mem_wa, mem_ra;
  logic [BYTE_W-1:0] mem_wd;

  logic              out_ready;

  assign out_ready = !ov_r || !out_stall;
  assign pop_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    cnt_nxt      = cnt_r;
    ch_nxt       = ch_r;
    rd_ok_nxt    = rd_ok_r;
    prev_len_nxt = prev_len_r;
    cursor_nxt   = cursor_r;
    len_nxt      = len_r;
    bank_nxt     = bank_r;
    ov_nxt       = ov_r && out_stall;
    o_ev_nxt     = o_ev_r;
    o_eb_nxt     = o_eb_r;
    o_brk_nxt    = o_brk_r;
    o_done_nxt   = o_done_r;
    o_len_nxt    = o_len_r;
    o_ovf_nxt    = o_ovf_r;
    o_rd_nxt     = o_rd_r;
    o_last_nxt   = o_last_r;
    mem_we       = 1'b0;
    mem_wa       = {bank_r, cursor_r};
    mem_wd       = CH_LF;
    mem_re       = 1'b0;
    mem_ra       = {~bank_r, pop_ent.idx[PW-1:0]};

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = S_SEQ;
          ch_nxt    = pop_ent.ch;
          cnt_nxt   = PW'(1);
          case (pop_ent.op)
            OP_READ: begin
              act_nxt   = A_READ;
              rd_ok_nxt = (LEN_W'(pop_ent.idx) < len_r);
              mem_re    = 1'b1;
            end
            OP_BREAK: begin
              act_nxt    = A_BREAK;
              cursor_nxt = '0;
            end
            OP_BS, OP_DEL: begin
              if (cursor_r != '0) begin
                act_nxt    = (pop_ent.op == OP_BS) ? A_BS : A_DEL;
                cnt_nxt    = (pop_ent.op == OP_BS) ? PW'(3) : PW'(1);
                cursor_nxt = cursor_r - PW'(1);
              end else begin
                act_nxt = A_NONE;
              end
            end
            OP_KILL: begin
              if (cursor_r != '0) begin
                act_nxt    = A_KILL;
                cnt_nxt    = cursor_r;
                cursor_nxt = '0;
              end else begin
                act_nxt = A_NONE;
              end
            end
            OP_CR, OP_LF: begin
              // commit: store LF, then swap banks
              act_nxt      = (pop_ent.op == OP_CR) ? A_CR : A_LF;
              cnt_nxt      = (pop_ent.op == OP_CR) ? PW'(2) : PW'(1);
              mem_we       = 1'b1;
              prev_len_nxt = len_r;
              len_nxt      = LEN_W'(cursor_r) + LEN_W'(1);
              bank_nxt     = ~bank_r;
              cursor_nxt   = '0;
            end
            default: begin
              if (cursor_r == PW'(LINE_LEN - 1)) begin
                act_nxt = A_OVF;
              end else begin
                act_nxt    = A_CHAR;
                mem_we     = 1'b1;
                mem_wd     = pop_ent.ch;
                cursor_nxt = cursor_r + PW'(1);
              end
            end
          endcase
        end
      end

      S_SEQ: begin
        if (out_ready) begin
          ov_nxt     = 1'b1;
          o_ev_nxt   = 1'b0;
          o_eb_nxt   = '0;
          o_brk_nxt  = 1'b0;
          o_done_nxt = 1'b0;
          o_len_nxt  = len_r;
          o_ovf_nxt  = 1'b0;
          o_rd_nxt   = '0;
          o_last_nxt = (cnt_r == PW'(1));
          case (act_r)
            A_READ:  o_rd_nxt  = rd_ok_r ? mem_q : '0;
            A_BREAK: o_brk_nxt = 1'b1;
            A_OVF:   o_ovf_nxt = 1'b1;
            A_BS: begin
              o_ev_nxt = 1'b1;
              o_eb_nxt = (cnt_r == PW'(2)) ? CH_SPACE : CH_BS;
            end
            A_DEL, A_KILL: begin
              o_ev_nxt = 1'b1;
              o_eb_nxt = CH_DEL;
            end
            A_CHAR: begin
              o_ev_nxt = 1'b1;
              o_eb_nxt = ch_r;
            end
            A_CR: begin
              o_ev_nxt = 1'b1;
              if (cnt_r == PW'(2)) begin
                // CR echo still reports the previous line length
                o_eb_nxt  = ch_r;
                o_len_nxt = prev_len_r;
              end else begin
                o_eb_nxt   = CH_LF;
                o_done_nxt = 1'b1;
              end
            end
            A_LF: begin
              o_ev_nxt   = 1'b1;
              o_eb_nxt   = CH_LF;
              o_done_nxt = 1'b1;
            end
            default: ;
          endcase
          cnt_nxt = cnt_r - PW'(1);
          if (cnt_r == PW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      len_r    <= '0;
      bank_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      len_r    <= len_nxt;
      bank_r   <= bank_nxt;
      ov_r     <= ov_nxt;
    end
    act_r      <= act_nxt;
    cnt_r      <= cnt_nxt;
    ch_r       <= ch_nxt;
    rd_ok_r    <= rd_ok_nxt;
    prev_len_r <= prev_len_nxt;
    o_ev_r     <= o_ev_nxt;
    o_eb_r     <= o_eb_nxt;
    o_brk_r    <= o_brk_nxt;
    o_done_r   <= o_done_nxt;
    o_len_r    <= o_len_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_rd_r     <= o_rd_nxt;
    o_last_r   <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  assign out_valid       = ov_r;
  assign out_echo_valid  = o_ev_r;
  assign out_echo_byte   = o_eb_r;
  assign out_break_event = o_brk_r;
  assign out_line_done   = o_done_r;
  assign out_line_length = o_len_r;
  assign out_overflow    = o_ovf_r;
  assign out_read_data   = o_rd_r;
  assign out_last        = o_last_r;

endmodule

// File: sv/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical-mode line discipline: edits a received line, emits echo bytes
// and status, and serves reads of the last completed line.
// ----------------------------------------------------------------------------
// Each accepted item produces one or more result transfers, the last one
// flagged by out_last: one for most bytes, two for CR, three for backspace,
// and up to LINE_LEN - 1 for Ctrl-U on a full line (one 7F echo per buffered
// character). An item is registered in the queue, then taken into the
// sequencer, which emits one result per cycle through its output register
// unless out_stall holds a pending result, and takes no new item until the
// current one is done. The input side keeps accepting into a
// two-entry queue while the back end works, so up to two items can wait.
// Committing a line (CR or LF) costs no copy: the line memory has two banks,
// and the bank being edited becomes the completed line by a bank swap.
// Read commands (in_cmd = 1) return one byte of the completed line, or 0 at
// or past its length. Any byte that would be stored other than as LF,
// arriving with LINE_LEN-1 characters buffered, is dropped and reported
// through out_overflow without an echo.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic [5:0] in_read_index,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_break_event,
  output logic       out_line_done,
  output logic [6:0] out_line_length,
  output logic       out_overflow,
  output logic [7:0] out_read_data,
  output logic       out_last
);
  import tle_pkg::*;

  logic  push_valid;
  qent_t push_ent;
  logic  q_full;
  logic  pop_valid;
  logic  pop_ready;
  qent_t pop_ent;

  // the input transfer completes whenever the queue has room
  assign in_stall = q_full;

  // front end: classify the byte or read command
  tle_front u_front (
    .in_valid      (in_valid),
    .in_cmd        (in_cmd),
    .in_rx_byte    (in_rx_byte),
    .in_read_index (in_read_index),
    .push_valid    (push_valid),
    .push_ent      (push_ent)
  );

  // decoupling queue
  tle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ent   (push_ent),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ent    (pop_ent)
  );

  // back end: line state, line memory and result sequencer
  tle_back #(
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_ent         (pop_ent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_echo_valid  (out_echo_valid),
    .out_echo_byte   (out_echo_byte),
    .out_break_event (out_break_event),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_overflow    (out_overflow),
    .out_read_data   (out_read_data),
    .out_last        (out_last)
  );

endmodule
